@@ sv/sstod_pkg.sv @@
// Shared types and constants for the serial-set time-of-day clock.
`default_nettype none

package sstod_pkg;

  // Number of words the queue between front and back can hold.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Value of the kind field on the input stream.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // Line terminator on the serial side.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CHAR,
    OP_EOL
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_TIME,
    ST_LED,
    ST_REJECT
  } status_e;

  // One classified word as it waits in the queue.
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } item_t;

  // Queue occupancy flags seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // One result word, field by field.
  typedef struct packed {
    status_e    line_status;
    logic       blue_on;
    logic       green_on;
    logic       red_on;
    logic [3:0] second_ones;
    logic [2:0] second_tens;
    logic [3:0] minute_ones;
    logic [2:0] minute_tens;
    logic [3:0] hour_ones;
    logic [1:0] hour_tens;
  } result_t;

endpackage

`default_nettype wire

@@ sv/sstod_front.sv @@
// Front end: accepts input words and sorts them into tick, character and end of line.
`default_nettype none

module sstod_front import sstod_pkg::*; (
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire queue_stat_t q_stat_i,
  output logic             push_o,
  output item_t            item_o
);

  assign s_ready_o = !q_stat_i.full;
  assign push_o    = s_valid_i && !q_stat_i.full;

  always_comb begin
    item_o.ch = rx_byte_i;
    if (kind_i == KIND_TICK) begin
      item_o.op = OP_TICK;
    end else if (rx_byte_i == CH_NEWLINE) begin
      item_o.op = OP_EOL;
    end else begin
      item_o.op = OP_CHAR;
    end
  end

endmodule

`default_nettype wire

@@ sv/sstod_fifo.sv @@
// Short queue of classified words between the front end and the back end.
`default_nettype none

module sstod_fifo import sstod_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  item_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign item_o       = slot_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/sstod_back.sv @@
// Back end: clock digits, line buffer, command decode and the output register.
`default_nettype none

module sstod_back import sstod_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  output logic       pop_o,
  output logic       res_valid_o,
  input  wire logic  res_ready_i,
  output result_t    res_o
);

  localparam int unsigned KEEP_MAX   = LINE_DEPTH - 1;
  localparam int unsigned CNT_W      = $clog2(LINE_DEPTH);
  // Only the first ten characters of a line are ever decoded.
  localparam int unsigned HEAD_LEN   = 10;
  localparam int unsigned HEAD_IDX_W = $clog2(HEAD_LEN);

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_Y    = 8'h59;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_Z    = 8'h5A;

  logic [7:0]       line_q [HEAD_LEN];
  logic [CNT_W-1:0] len_q, len_d;
  logic [1:0]       h_t_q, h_t_d;
  logic [3:0]       h_o_q, h_o_d;
  logic [2:0]       m_t_q, m_t_d;
  logic [3:0]       m_o_q, m_o_d;
  logic [2:0]       s_t_q, s_t_d;
  logic [3:0]       s_o_q, s_o_d;
  logic [2:0]       led_q, led_d;
  logic             res_valid_q, res_valid_d;
  result_t          res_q;
  status_e          status;
  logic             wr_en;
  logic             digits_ok, range_ok, time_ok;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  assign pop_o = item_valid_i && (!res_valid_q || res_ready_i);

  // A set-time line needs ten characters, digits at the six digit places and legal values.
  assign digits_ok = is_digit(line_q[2]) && is_digit(line_q[3]) && is_digit(line_q[5]) &&
                     is_digit(line_q[6]) && is_digit(line_q[8]) && is_digit(line_q[9]);
  assign range_ok  = ((line_q[2][3:0] < 4'd2) ||
                      ((line_q[2][3:0] == 4'd2) && (line_q[3][3:0] <= 4'd3))) &&
                     (line_q[5][3:0] <= 4'd5) && (line_q[8][3:0] <= 4'd5);
  assign time_ok   = (len_q >= CNT_W'(HEAD_LEN)) && digits_ok && range_ok;

  always_comb begin
    len_d  = len_q;
    h_t_d  = h_t_q;
    h_o_d  = h_o_q;
    m_t_d  = m_t_q;
    m_o_d  = m_o_q;
    s_t_d  = s_t_q;
    s_o_d  = s_o_q;
    led_d  = led_q;
    status = ST_NONE;
    wr_en  = 1'b0;
    if (pop_o) begin
      case (item_i.op)
        OP_TICK: begin
          if (s_o_q != 4'd9) begin
            s_o_d = s_o_q + 4'd1;
          end else begin
            s_o_d = '0;
            if (s_t_q != 3'd5) begin
              s_t_d = s_t_q + 3'd1;
            end else begin
              s_t_d = '0;
              if (m_o_q != 4'd9) begin
                m_o_d = m_o_q + 4'd1;
              end else begin
                m_o_d = '0;
                if (m_t_q != 3'd5) begin
                  m_t_d = m_t_q + 3'd1;
                end else begin
                  m_t_d = '0;
                  if ((h_t_q == 2'd2) && (h_o_q == 4'd3)) begin
                    h_t_d = '0;
                    h_o_d = '0;
                  end else if (h_o_q == 4'd9) begin
                    h_o_d = '0;
                    h_t_d = h_t_q + 2'd1;
                  end else begin
                    h_o_d = h_o_q + 4'd1;
                  end
                end
              end
            end
          end
        end
        OP_CHAR: begin
          if (len_q < CNT_W'(KEEP_MAX)) begin
            len_d = len_q + 1'b1;
            wr_en = (len_q < CNT_W'(HEAD_LEN));
          end
        end
        OP_EOL: begin
          len_d = '0;
          if (len_q < CNT_W'(2)) begin
            status = ST_REJECT;
          end else if ((line_q[0] == CH_ZERO) && (line_q[1] == CH_ZERO)) begin
            if (time_ok) begin
              status = ST_TIME;
              h_t_d  = line_q[2][1:0];
              h_o_d  = line_q[3][3:0];
              m_t_d  = line_q[5][2:0];
              m_o_d  = line_q[6][3:0];
              s_t_d  = line_q[8][2:0];
              s_o_d  = line_q[9][3:0];
            end else begin
              status = ST_REJECT;
            end
          end else if (line_q[1] != CH_ZERO) begin
            status = ST_REJECT;
          end else begin
            status = ST_LED;
            case (line_q[0])
              CH_R:    led_d[0] = 1'b1;
              CH_X:    led_d[0] = 1'b0;
              CH_G:    led_d[1] = 1'b1;
              CH_Y:    led_d[1] = 1'b0;
              CH_B:    led_d[2] = 1'b1;
              CH_Z:    led_d[2] = 1'b0;
              default: status   = ST_REJECT;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (pop_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      h_t_q       <= '0;
      h_o_q       <= '0;
      m_t_q       <= '0;
      m_o_q       <= '0;
      s_t_q       <= '0;
      s_o_q       <= '0;
      led_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      h_t_q       <= h_t_d;
      h_o_q       <= h_o_d;
      m_t_q       <= m_t_d;
      m_o_q       <= m_o_d;
      s_t_q       <= s_t_d;
      s_o_q       <= s_o_d;
      led_q       <= led_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_q[len_q[HEAD_IDX_W-1:0]] <= item_i.ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q.line_status <= status;
      res_q.red_on      <= led_d[0];
      res_q.green_on    <= led_d[1];
      res_q.blue_on     <= led_d[2];
      res_q.hour_tens   <= h_t_d;
      res_q.hour_ones   <= h_o_d;
      res_q.minute_tens <= m_t_d;
      res_q.minute_ones <= m_o_d;
      res_q.second_tens <= s_t_d;
      res_q.second_ones <= s_o_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ sv/serial_set_time_of_day_clock_top.sv @@
// An accepted word is stored in the queue, then the back end pops it and registers its result.
// Throughput: one word per cycle while the output is not stalled.
// The two-entry queue between front and back takes input during output stalls until full.
// Reset (rst_ni low, asynchronous) clears the time to 00:00:00, all LEDs off, the line empty
// and the queue and the valid flag; line characters and output data are undefined until set.
`default_nettype none

module serial_set_time_of_day_clock_top import sstod_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser_i,   // [0] kind: 0 one-second tick, 1 serial byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // [1:0] hour_tens, [5:2] hour_ones,
                                             // [8:6] minute_tens, [12:9] minute_ones,
                                             // [15:13] second_tens, [19:16] second_ones,
                                             // [20] red_on, [21] green_on, [22] blue_on,
                                             // [24:23] line_status, [31:25] zero
);

  // The front end only classifies a word and pushes it into the queue; it stalls
  // the input stream only when the queue is full.
  logic        push;
  item_t       push_item;
  queue_stat_t q_stat;

  // The back end pops a word whenever its output register is free or being drained.
  logic        pop;
  item_t       pop_item;
  result_t     res;

  sstod_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .kind_i    (s_axis_tuser_i),
    .rx_byte_i (s_axis_tdata_i),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .item_o    (push_item)
  );

  sstod_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  sstod_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_stat.empty),
    .item_i       (pop_item),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  // Pack the result word, hour_tens in the lowest bits and zero padding at the top.
  assign m_axis_tdata_o = {7'b0, res.line_status, res.blue_on, res.green_on, res.red_on,
                           res.second_ones, res.second_tens, res.minute_ones,
                           res.minute_tens, res.hour_ones, res.hour_tens};

`ifndef SYNTHESIS
  // A word pushed into an empty queue must still be there in the next cycle.
  a_push_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && q_stat.empty) |=> !q_stat.empty)
    else $error("queue lost a word pushed while empty");

  // Ticks and plain characters never report a line outcome.
  a_no_line_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (pop_item.op == OP_TICK || pop_item.op == OP_CHAR)) |=>
    (res.line_status == ST_NONE))
    else $error("line status set by a word that ends no line");

  // Valid result words always carry legal seconds digits.
  a_second_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res.second_ones <= 4'd9 && res.second_tens <= 3'd5))
    else $error("seconds digits out of range");
`endif

endmodule

`default_nettype wire
